@@ rtl/adcirb_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC interface register block package
// Shared constants, register word indexes, command codes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package adcirb_pkg;

    // Default sizes of the ADC register bank and the read-data FIFO.
    localparam int ADC_REG_COUNT_DEF = 128;
    localparam int FIFO_DEPTH_DEF    = 15;

    // Field widths.
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 10;
    localparam int HALF_W    = 16;
    localparam int REGNUM_W  = 10;
    localparam int CMD_W     = 4;
    localparam int COUNT_W   = 4;

    // Register word indexes.
    localparam logic [INDEX_W-1:0] REG_CONFIG  = 10'd0;
    localparam logic [INDEX_W-1:0] REG_STATUS  = 10'd1;
    localparam logic [INDEX_W-1:0] REG_MASK    = 10'd2;
    localparam logic [INDEX_W-1:0] REG_MSTATUS = 10'd3;
    localparam logic [INDEX_W-1:0] REG_COMMAND = 10'd4;
    localparam logic [INDEX_W-1:0] REG_RDFIFO  = 10'd5;
    localparam logic [INDEX_W-1:0] REG_MCTRL   = 10'd6;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Command codes carried in a command word.
    localparam logic [CMD_W-1:0] CMD_NOP   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_FETCH = 4'd1;
    localparam logic [CMD_W-1:0] CMD_STORE = 4'd2;

    // Reset values.
    localparam logic [DATA_W-1:0] CONFIG_RESET = 32'h0000_1814;
    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0200;
    localparam logic [DATA_W-1:0] MASK_RESET   = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] MCTRL_RESET  = 32'h0000_0010;

    // Write masks.
    localparam logic [DATA_W-1:0] MASK_WR_MASK  = 32'h0000_03ff;
    localparam logic [DATA_W-1:0] MCTRL_WR_MASK = 32'h00ff_feff;

    // Bit positions.
    localparam int MCTRL_RESET_BIT  = 4;
    localparam int STATUS_ALWAYS    = 9;
    localparam int STATUS_THRESHOLD = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted beat and read the bank
        logic execute;   // apply the access and register the result
        logic clear;     // write one zero word of the clearing pass
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // the clearing pass is at its last word
    } dp_status_t;

endpackage

@@ rtl/adcirb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ADC interface register block controller
// Sequences the bank clearing pass after reset, then accepts one bus access
// at a time and has the datapath execute it in the following cycle.
// ----------------------------------------------------------------------------
module adcirb_ctrl
    import adcirb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.clear   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // An accepted beat is always executed in the very next cycle.
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("Accepted beat was not executed in the next cycle.");

    // The block never accepts a beat during the clearing pass.
    a_no_capture_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !cmd.capture && busy)
        else $error("Beat accepted during the clearing pass.");

    // After execution the block is ready again.
    a_exec_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> !busy)
        else $error("Block stayed busy after executing a beat.");

endmodule

@@ rtl/adcirb_datapath.sv @@
// ----------------------------------------------------------------------------
// ADC interface register block datapath
// Holds the control registers, the ADC register bank, the read-data FIFO and
// the holding register, and produces the registered result of each access.
// ----------------------------------------------------------------------------
module adcirb_datapath
    import adcirb_pkg::*;
#(
    parameter int ADC_REG_COUNT = ADC_REG_COUNT_DEF,
    parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               op,
    input  logic [INDEX_W-1:0] word_index,
    input  logic [DATA_W-1:0]  write_data,
    output logic               done,
    output logic [DATA_W-1:0]  read_data,
    output logic               irq,
    output logic               access_error
);

    localparam int ADDR_W = (ADC_REG_COUNT > 1) ? $clog2(ADC_REG_COUNT) : 1;
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // Captured access.
    logic               op_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [DATA_W-1:0]  wdata_reg;

    // Control registers.
    logic [DATA_W-1:0] config_reg;
    logic [DATA_W-1:0] config_next;
    logic [DATA_W-1:0] status_reg;
    logic [DATA_W-1:0] status_next;
    logic [DATA_W-1:0] mask_reg;
    logic [DATA_W-1:0] mask_next;
    logic [DATA_W-1:0] mctrl_reg;
    logic [DATA_W-1:0] mctrl_next;

    // ADC register bank.
    logic [HALF_W-1:0] bank_mem [ADC_REG_COUNT];
    logic [HALF_W-1:0] bank_rd_reg;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic              bank_wr;
    logic [ADDR_W-1:0] bank_waddr;
    logic [HALF_W-1:0] bank_wdata;

    // Read-data FIFO and holding register.
    logic [HALF_W-1:0]  fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   head_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [HALF_W-1:0]  held_reg;
    logic [HALF_W-1:0]  held_next;
    logic [COUNT_W:0]   tail_sum;
    logic [PTR_W-1:0]   tail;

    // Result registers.
    logic              done_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              irq_reg;
    logic              err_reg;

    // Decoded access.
    logic               ok;
    logic               rd_en;
    logic               wr_en;
    logic [CMD_W-1:0]   cmd_code;
    logic [REGNUM_W-1:0] reg_num;
    logic               in_range;
    logic               run;
    logic               push;
    logic               pop;
    logic [DATA_W-1:0]  rd_value;
    logic [DATA_W-1:0]  mstatus;

    // Access check: which indexes exist and in which direction.
    always_comb
    begin
        case (index_reg)
            REG_CONFIG, REG_STATUS, REG_MASK, REG_MCTRL: ok = 1'b1;
            REG_MSTATUS, REG_RDFIFO:                     ok = (op_reg == OP_READ);
            REG_COMMAND:                                 ok = (op_reg == OP_WRITE);
            default:                                     ok = 1'b0;
        endcase
    end

    assign rd_en = ok && (op_reg == OP_READ);
    assign wr_en = ok && (op_reg == OP_WRITE);

    // Command word decode.
    assign cmd_code = wdata_reg[29:26];
    assign reg_num  = wdata_reg[25:16];
    assign in_range = ({1'b0, reg_num} < (REGNUM_W+1)'(ADC_REG_COUNT));

    always_comb
    begin
        run = 1'b0;
        if (wr_en && (index_reg == REG_COMMAND) && !mctrl_reg[MCTRL_RESET_BIT])
        begin
            case (cmd_code)
                CMD_NOP:              run = 1'b1;
                CMD_FETCH, CMD_STORE: run = in_range;
                default:              run = 1'b0;
            endcase
        end
    end

    assign push = run && (count_reg < COUNT_W'(FIFO_DEPTH));
    assign pop  = rd_en && (index_reg == REG_RDFIFO) && (count_reg != '0);

    // FIFO tail position, wrapped at the depth.
    always_comb
    begin
        tail_sum = (COUNT_W+1)'(head_reg) + (COUNT_W+1)'(count_reg);
        if (tail_sum >= (COUNT_W+1)'(FIFO_DEPTH))
        begin
            tail_sum = tail_sum - (COUNT_W+1)'(FIFO_DEPTH);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    // Master status word.
    always_comb
    begin
        mstatus = 32'h0000_0400 | (DATA_W'(count_reg) << 12);
        if (count_reg == '0)
        begin
            mstatus[8] = 1'b1;
        end
        else if (count_reg == COUNT_W'(FIFO_DEPTH))
        begin
            mstatus[9] = 1'b1;
        end
    end

    // Read data selection.
    always_comb
    begin
        rd_value = '0;
        if (rd_en)
        begin
            case (index_reg)
                REG_CONFIG:  rd_value = config_reg;
                REG_STATUS:  rd_value = status_reg;
                REG_MASK:    rd_value = mask_reg;
                REG_MCTRL:   rd_value = mctrl_reg;
                REG_MSTATUS: rd_value = mstatus;
                REG_RDFIFO:
                begin
                    if (count_reg != '0)
                    begin
                        rd_value = DATA_W'(fifo_mem[head_reg]);
                    end
                end
                default:     rd_value = '0;
            endcase
        end
    end

    // Register updates followed by the interrupt status update.
    always_comb
    begin
        config_next = config_reg;
        status_next = status_reg;
        mask_next   = mask_reg;
        mctrl_next  = mctrl_reg;
        count_next  = count_reg;
        held_next   = held_reg;
        if (wr_en)
        begin
            case (index_reg)
                REG_CONFIG: config_next = wdata_reg;
                REG_STATUS: status_next = status_reg & ~wdata_reg;
                REG_MASK:   mask_next   = wdata_reg & MASK_WR_MASK;
                REG_MCTRL:  mctrl_next  = wdata_reg & MCTRL_WR_MASK;
                default:    config_next = config_reg;
            endcase
        end
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
        if (run)
        begin
            held_next = (cmd_code == CMD_FETCH) ? bank_rd_reg : '0;
        end
        status_next[STATUS_ALWAYS] = 1'b1;
        if (count_next > config_next[19:16])
        begin
            status_next[STATUS_THRESHOLD] = 1'b1;
        end
    end

    // Bank write port: the clearing pass or a write command.
    assign bank_wr    = cmd.clear || (cmd.execute && run && (cmd_code == CMD_STORE));
    assign bank_waddr = cmd.clear ? clear_addr_reg : reg_num[ADDR_W-1:0];
    assign bank_wdata = cmd.clear ? '0 : wdata_reg[HALF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (bank_wr)
        begin
            bank_mem[bank_waddr] <= bank_wdata;
        end
        if (cmd.capture)
        begin
            bank_rd_reg <= bank_mem[write_data[16 +: ADDR_W]];
        end
    end

    // Clearing pass address counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    assign status.clear_last = (clear_addr_reg == ADDR_W'(ADC_REG_COUNT - 1));

    // FIFO storage.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && push)
        begin
            fifo_mem[tail] <= held_reg;
        end
    end

    // Captured access.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            index_reg <= word_index;
            wdata_reg <= write_data;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rdata_reg <= rd_value;
            irq_reg   <= |(status_next & ~mask_next);
            err_reg   <= !ok;
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_reg <= CONFIG_RESET;
            status_reg <= STATUS_RESET;
            mask_reg   <= MASK_RESET;
            mctrl_reg  <= MCTRL_RESET;
            head_reg   <= '0;
            count_reg  <= '0;
            held_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
            if (cmd.execute)
            begin
                config_reg <= config_next;
                status_reg <= status_next;
                mask_reg   <= mask_next;
                mctrl_reg  <= mctrl_next;
                count_reg  <= count_next;
                held_reg   <= held_next;
                if (pop)
                begin
                    head_reg <= (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                end
            end
        end
    end

    assign done         = done_reg;
    assign read_data    = rdata_reg;
    assign irq          = irq_reg;
    assign access_error = err_reg;

    // The FIFO never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FIFO_DEPTH))
        else $error("FIFO count exceeds its depth.");

    // Every executed access yields exactly one result beat.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> done && !$past(done))
        else $error("Executed access did not give a single result beat.");

    // A push and a pop never happen in the same access.
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !(push && pop))
        else $error("FIFO push and pop in the same access.");

    // An access error always comes with zero read data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && access_error |-> read_data == '0)
        else $error("Access error beat carries nonzero read data.");

endmodule

@@ rtl/adc_interface_register_block.sv @@
// ----------------------------------------------------------------------------
// ADC interface register block
// Top level: bus access controller and register datapath.
// ----------------------------------------------------------------------------
// Each access is accepted when start is high and busy is low, executed in the
// next cycle while busy is high, and its result beat is on read_data, irq and
// access_error for the one cycle that done is high, during which a new access
// may already be accepted. The execution state is needed for the registered
// read port of the ADC register bank, which a read command consults. The
// receiver cannot stall the result beat. After reset the block stays busy
// while it clears the register bank one word per cycle.
// ----------------------------------------------------------------------------
module adc_interface_register_block
    import adcirb_pkg::*;
#(
    parameter int ADC_REG_COUNT = ADC_REG_COUNT_DEF,
    parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [INDEX_W-1:0] word_index,
    input  logic [DATA_W-1:0]  write_data,
    output logic               done,
    output logic [DATA_W-1:0]  read_data,
    output logic               irq,
    output logic               access_error
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Access sequencing.
    adcirb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (dp_cmd),
        .status (dp_status)
    );

    // Registers, bank and FIFO.
    adcirb_datapath #(
        .ADC_REG_COUNT (ADC_REG_COUNT),
        .FIFO_DEPTH    (FIFO_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .op           (op),
        .word_index   (word_index),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .irq          (irq),
        .access_error (access_error)
    );

endmodule

@@ verif/adc_interface_register_block_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC interface register block testbench
// Drives single bus accesses through the start/busy handshake and compares
// every result beat against a cycle-free model of the register file, the
// command path, the holding register and the read-data FIFO. A short table of
// directed accesses comes first, followed by randomized segments that mix
// command traffic, FIFO pops, register accesses and malformed accesses.
// ----------------------------------------------------------------------------
module adc_interface_register_block_tb;
    import adcirb_pkg::*;

    // Expected contents of one result beat.
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
        logic              err;
    } access_result_t;

    // One row of the directed table.
    typedef struct {
        logic               op;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  data;
        logic               typed;
        access_result_t     res;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               op = 1'b0;
    logic [INDEX_W-1:0] word_index = '0;
    logic [DATA_W-1:0]  write_data = '0;
    logic               busy;
    logic               done;
    logic [DATA_W-1:0]  read_data;
    logic               irq;
    logic               access_error;

    // Shadow copy of the block state.
    logic [DATA_W-1:0]  cfg_word;
    logic [DATA_W-1:0]  int_status;
    logic [DATA_W-1:0]  irq_mask_word;
    logic [DATA_W-1:0]  mctrl_word;
    logic [HALF_W-1:0]  adc_bank [ADC_REG_COUNT_DEF];
    logic [HALF_W-1:0]  rd_fifo [$];
    logic [HALF_W-1:0]  held_value;

    access_result_t     pending_beats [$];
    directed_row_t      directed_rows [$];
    access_result_t     want;
    access_result_t     blank_res = '0;
    int                 fail_count = 0;
    int                 beats_seen = 0;
    bit                 no_idle = 1'b0;

    adc_interface_register_block dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .word_index   (word_index),
        .write_data   (write_data),
        .done         (done),
        .read_data    (read_data),
        .irq          (irq),
        .access_error (access_error)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one access to the shadow state and returns the beat it causes.
    function automatic access_result_t apply_bus_access(input logic op_i,
                                                        input logic [INDEX_W-1:0] idx_i,
                                                        input logic [DATA_W-1:0] wdata);
        access_result_t    res;
        logic              legal;
        logic [DATA_W-1:0] rdata;
        logic [CMD_W-1:0]  cmd;
        logic [REGNUM_W-1:0] regnum;
        logic [HALF_W-1:0] next_held;
        int                cnt;

        rdata = '0;
        case (idx_i)
            REG_CONFIG, REG_STATUS, REG_MASK, REG_MCTRL: legal = 1'b1;
            REG_MSTATUS, REG_RDFIFO:                     legal = (op_i == OP_READ);
            REG_COMMAND:                                 legal = (op_i == OP_WRITE);
            default:                                     legal = 1'b0;
        endcase

        if (legal && op_i == OP_READ)
        begin
            case (idx_i)
                REG_CONFIG: rdata = cfg_word;
                REG_STATUS: rdata = int_status;
                REG_MASK:   rdata = irq_mask_word;
                REG_MCTRL:  rdata = mctrl_word;
                REG_MSTATUS:
                begin
                    // Command FIFO empty is always reported, then count and flags.
                    cnt = rd_fifo.size();
                    rdata = 32'h0000_0400 | (cnt << 12);
                    if (cnt == 0)
                        rdata[8] = 1'b1;
                    else if (cnt == FIFO_DEPTH_DEF)
                        rdata[9] = 1'b1;
                end
                REG_RDFIFO:
                begin
                    // Popping an empty FIFO returns zero.
                    if (rd_fifo.size() > 0)
                        rdata = {16'h0000, rd_fifo.pop_front()};
                end
                default: ;
            endcase
        end
        else if (legal)
        begin
            case (idx_i)
                REG_CONFIG: cfg_word = wdata;
                REG_STATUS: int_status = int_status & ~wdata;
                REG_MASK:   irq_mask_word = wdata & MASK_WR_MASK;
                REG_MCTRL:  mctrl_word = wdata & MCTRL_WR_MASK;
                REG_COMMAND:
                begin
                    cmd = wdata[29:26];
                    regnum = wdata[25:16];
                    // Commands are dropped in reset and for out-of-range
                    // registers, though a nop runs whatever its register number.
                    if (!mctrl_word[MCTRL_RESET_BIT]
                        && (regnum < ADC_REG_COUNT_DEF || cmd == CMD_NOP)
                        && (cmd == CMD_NOP || cmd == CMD_FETCH || cmd == CMD_STORE))
                    begin
                        next_held = '0;
                        if (cmd == CMD_FETCH)
                            next_held = adc_bank[regnum];
                        if (cmd == CMD_STORE)
                            adc_bank[regnum] = wdata[15:0];
                        // A full FIFO drops the push but the hold still moves on.
                        if (rd_fifo.size() < FIFO_DEPTH_DEF)
                            rd_fifo.push_back(held_value);
                        held_value = next_held;
                    end
                end
                default: ;
            endcase
        end

        // Interrupt update after every access.
        int_status[STATUS_ALWAYS] = 1'b1;
        if (rd_fifo.size() > cfg_word[19:16])
            int_status[STATUS_THRESHOLD] = 1'b1;

        res.rdata = rdata;
        res.irq   = |(int_status & ~irq_mask_word);
        res.err   = !legal;
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want_v);
        $display("MISMATCH %s: got %h, expected %h (beat %0d)", what, got, want_v,
                 beats_seen);
        fail_count++;
    endtask

    task automatic add_row(input logic op_i, input logic [INDEX_W-1:0] idx_i,
                           input logic [DATA_W-1:0] data_i, input logic typed,
                           input logic [DATA_W-1:0] rdata, input logic irq_i,
                           input logic err_i);
        directed_row_t row;
        row.op = op_i;
        row.idx = idx_i;
        row.data = data_i;
        row.typed = typed;
        row.res = '{rdata: rdata, irq: irq_i, err: err_i};
        directed_rows.push_back(row);
    endtask

    // Sends one access after a random gap and queues its expected beat.
    task automatic send_access(input logic op_i, input logic [INDEX_W-1:0] idx_i,
                               input logic [DATA_W-1:0] data_i, input logic typed,
                               input access_result_t typed_res);
        int             gap;
        access_result_t res;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        op         <= op_i;
        word_index <= idx_i;
        write_data <= data_i;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = apply_bus_access(op_i, idx_i, data_i);
        pending_beats.push_back(typed ? typed_res : res);
    endtask

    // Result beat checker.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            beats_seen++;
            if (pending_beats.size() == 0)
                report_mismatch("beat with nothing expected", read_data, '0);
            else
            begin
                want = pending_beats.pop_front();
                if (read_data !== want.rdata)
                    report_mismatch("read_data", read_data, want.rdata);
                if (irq !== want.irq)
                    report_mismatch("irq", {31'h0, irq}, {31'h0, want.irq});
                if (access_error !== want.err)
                    report_mismatch("access_error", {31'h0, access_error},
                                    {31'h0, want.err});
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int                  seg;
        int                  n;
        int                  r;
        int                  cmd_w;
        int                  k;
        int                  drain;
        logic                rop;
        logic [INDEX_W-1:0]  ridx;
        logic [DATA_W-1:0]   rdat;
        logic [CMD_W-1:0]    rcmd;
        logic [REGNUM_W-1:0] rreg;

        cfg_word      = CONFIG_RESET;
        int_status    = STATUS_RESET;
        irq_mask_word = MASK_RESET;
        mctrl_word    = MCTRL_RESET;
        held_value    = '0;
        foreach (adc_bank[i])
            adc_bank[i] = '0;

        // Reset values, illegal accesses and the empty FIFO.
        add_row(OP_READ,  REG_CONFIG,  '0, 1'b1, CONFIG_RESET, 1'b0, 1'b0);
        add_row(OP_READ,  REG_STATUS,  '0, 1'b1, STATUS_RESET, 1'b0, 1'b0);
        add_row(OP_READ,  REG_MASK,    '0, 1'b1, MASK_RESET, 1'b0, 1'b0);
        add_row(OP_READ,  REG_MSTATUS, '0, 1'b1, 32'h0000_0500, 1'b0, 1'b0);
        add_row(OP_READ,  REG_MCTRL,   '0, 1'b1, MCTRL_RESET, 1'b0, 1'b0);
        add_row(OP_READ,  REG_RDFIFO,  '0, 1'b1, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_MSTATUS, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b1);
        add_row(OP_READ,  REG_COMMAND, '0, 1'b1, '0, 1'b0, 1'b1);
        add_row(OP_READ,  10'd7,       '0, 1'b1, '0, 1'b0, 1'b1);
        add_row(OP_WRITE, 10'd1023,    32'hffff_ffff, 1'b1, '0, 1'b0, 1'b1);
        // A command while the reset bit is set is ignored.
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_STORE, 10'd5, 16'habcd},
                1'b1, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_MCTRL,   32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
        add_row(OP_READ,  REG_MCTRL,   '0, 1'b1, MCTRL_WR_MASK, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_MCTRL,   '0, 1'b1, '0, 1'b0, 1'b0);
        // Command traffic, out-of-range registers and an unknown code.
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_STORE, 10'd0, 16'hffff},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b11, CMD_STORE, 10'd127, 16'h1234},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_FETCH, 10'd127, 16'h0000},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_FETCH, 10'd0, 16'h0000},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_FETCH, 10'd1023, 16'h0000},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b00, CMD_NOP, 10'd1023, 16'hffff},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_COMMAND, {2'b11, 4'hf, 10'd3, 16'h5555},
                1'b0, '0, 1'b0, 1'b0);
        add_row(OP_READ,  REG_RDFIFO,  '0, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_READ,  REG_MSTATUS, '0, 1'b0, '0, 1'b0, 1'b0);
        // Unmasking everything raises the interrupt at once.
        add_row(OP_WRITE, REG_MASK,    '0, 1'b1, '0, 1'b1, 1'b0);
        add_row(OP_WRITE, REG_STATUS,  32'hffff_ffff, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_WRITE, REG_CONFIG,  32'hffff_ffff, 1'b0, '0, 1'b0, 1'b0);
        add_row(OP_READ,  REG_STATUS,  '0, 1'b0, '0, 1'b0, 1'b0);

        // Reset is held first; the clearing pass then keeps busy high.
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_access(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].res);

        // Random segments with their own mix of commands and pops.
        for (seg = 0; seg < 19; seg++)
        begin
            cmd_w = $urandom_range(25, 60);
            no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                rdat = $urandom;
                if (r < cmd_w)
                begin
                    k = $urandom_range(0, 19);
                    if (k < 6)
                        rcmd = CMD_FETCH;
                    else if (k < 12)
                        rcmd = CMD_STORE;
                    else if (k < 16)
                        rcmd = CMD_NOP;
                    else
                        rcmd = CMD_W'($urandom_range(3, 15));
                    if ($urandom_range(0, 99) < 85)
                        rreg = REGNUM_W'($urandom_range(0, ADC_REG_COUNT_DEF - 1));
                    else
                        rreg = REGNUM_W'($urandom_range(ADC_REG_COUNT_DEF, 1023));
                    rdat[29:26] = rcmd;
                    rdat[25:16] = rreg;
                    rop = OP_WRITE;
                    ridx = REG_COMMAND;
                end
                else if (r < cmd_w + 20)
                begin
                    rop = OP_READ;
                    ridx = REG_RDFIFO;
                end
                else if (r < cmd_w + 30)
                begin
                    rop = OP_READ;
                    ridx = INDEX_W'($urandom_range(0, 6));
                end
                else if (r < cmd_w + 38)
                begin
                    k = $urandom_range(0, 3);
                    rop = OP_WRITE;
                    ridx = (k == 0) ? REG_CONFIG : (k == 1) ? REG_STATUS :
                           (k == 2) ? REG_MASK : REG_MCTRL;
                    // Keep the command path mostly out of reset.
                    if (ridx == REG_MCTRL && $urandom_range(0, 4) != 0)
                        rdat[MCTRL_RESET_BIT] = 1'b0;
                end
                else
                begin
                    rop = 1'($urandom_range(0, 1));
                    ridx = INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 1023) :
                                    $urandom_range(0, 15));
                end
                send_access(rop, ridx, rdat, 1'b0, blank_res);
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // Wait for the outstanding beats, then let the clock run on before the final check.
        drain = 0;
        while (pending_beats.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_beats.size() != 0)
            report_mismatch("beats never delivered", pending_beats.size(), '0);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ adc_interface_register_block.f @@
rtl/adcirb_pkg.sv
rtl/adcirb_ctrl.sv
rtl/adcirb_datapath.sv
rtl/adc_interface_register_block.sv
verif/adc_interface_register_block_tb.sv
